/* design/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
// Used by bpa_ctrl, bpa_datapath and bitmap_page_allocator_top; no dependencies.
`default_nettype none

package bpa_pkg;

	// map geometry
	localparam int unsigned PAGES     = 65536;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned BIT_W     = $clog2(WORD_W);
	localparam int unsigned MAP_WORDS = (PAGES + WORD_W - 1) / WORD_W;
	localparam int unsigned WADDR_W   = $clog2(MAP_WORDS);
	localparam int unsigned WCNT_W    = $clog2(MAP_WORDS + 1);
	localparam int unsigned IDX_W     = WCNT_W + BIT_W;
	localparam int unsigned PG_W      = $clog2(PAGES);
	localparam int unsigned CNT_W     = $clog2(PAGES + 1);
	localparam int unsigned PAGE_SH   = 12;
	localparam int unsigned BYTE_CNT  = WORD_W / 8;
	localparam int unsigned DELTA_W   = $clog2(WORD_W + 1);

	// field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned PADDR_W = 32;
	localparam int unsigned RANGE_W = 64;
	localparam int unsigned AADDR_W = 28;
	localparam int unsigned TOTAL_W = 17;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_RESERVE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_MODIFY,
		ST_ACC,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic rd;
		logic modify;
		logic acc;
		logic clr_wr;
	} dp_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic more;
		logic found;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* design/bpa_ctrl.sv */
// Controller state machine of the bitmap page allocator: clear pass, word loop, result hand-off.
// Depends on bpa_pkg.
`default_nettype none

module bpa_ctrl
	import bpa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     out_busy,
	input  wire dp_stat_t stat,
	output dp_ctrl_t      ctrl,
	output logic          in_stall,
	output logic          out_load
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		ctrl      = '0;
		out_load  = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_nxt = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctrl.setup = 1'b1;
				state_nxt  = ST_READ;
			end
			ST_READ: begin
				if (stat.more) begin
					ctrl.rd   = 1'b1;
					state_nxt = ST_MODIFY;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_MODIFY: begin
				ctrl.modify = 1'b1;
				state_nxt   = ST_ACC;
			end
			ST_ACC: begin
				ctrl.acc  = 1'b1;
				state_nxt = stat.found ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!out_busy) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/bpa_datapath.sv */
// Datapath of the bitmap page allocator: bitmap memory, page range, word walk and counters.
// Depends on bpa_pkg; driven by bpa_ctrl.
`default_nettype none

module bpa_datapath
	import bpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_ctrl_t           ctrl,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [PADDR_W-1:0] page_address,
	input  wire logic [RANGE_W-1:0] range_start,
	input  wire logic [RANGE_W-1:0] range_end,
	output dp_stat_t                stat,
	output logic [AADDR_W-1:0]      alloc_addr,
	output logic [TOTAL_W-1:0]      limit,
	output logic [TOTAL_W-1:0]      free_cnt
);

	localparam int unsigned RPG_W = RANGE_W - PAGE_SH;
	localparam int unsigned FPG_W = PADDR_W - PAGE_SH;

	logic [WORD_W-1:0]   map_mem [MAP_WORDS];
	logic [WORD_W-1:0]   rdata_q;

	cmd_t                cmd_q;
	logic [PADDR_W-1:0]  paddr_q;
	logic [RANGE_W-1:0]  start_q;
	logic [RANGE_W-1:0]  end_q;
	logic [CNT_W-1:0]    first_q;
	logic [CNT_W-1:0]    last_q;
	logic [WCNT_W-1:0]   w_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    free_q;
	logic                found_q;
	logic [PG_W-1:0]     apage_q;
	logic [3:0]          bcnt_q [BYTE_CNT];

	logic [CNT_W-1:0]    first_nxt;
	logic [CNT_W-1:0]    last_nxt;
	logic [CNT_W-1:0]    limit_nxt;
	logic [RPG_W:0]      s_up;
	logic [RPG_W:0]      e_up;
	logic [FPG_W-1:0]    fpage;
	logic [WORD_W-1:0]   mask;
	logic [WORD_W-1:0]   cand;
	logic [WORD_W-1:0]   onehot;
	logic [BIT_W-1:0]    bit_idx;
	logic [WORD_W-1:0]   new_word;
	logic [WORD_W-1:0]   changed;
	logic [IDX_W-1:0]    pg_i;
	logic [DELTA_W-1:0]  delta;

	// latch the command
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= cmd_t'(cmd);
			paddr_q <= page_address;
			start_q <= range_start;
			end_q   <= range_end;
		end
	end

	// page bounds of the command
	always_comb begin
		s_up      = {1'b0, start_q[RANGE_W-1:PAGE_SH]} + (RPG_W+1)'(|start_q[PAGE_SH-1:0]);
		e_up      = {1'b0, end_q[RANGE_W-1:PAGE_SH]} + (RPG_W+1)'(|end_q[PAGE_SH-1:0]);
		fpage     = paddr_q[PADDR_W-1:PAGE_SH];
		first_nxt = '0;
		last_nxt  = '0;
		limit_nxt = limit_q;
		unique case (cmd_q)
			CMD_ALLOC: begin
				first_nxt = CNT_W'(1);
				last_nxt  = limit_q;
			end
			CMD_FREE: begin
				if (fpage != '0 && fpage < FPG_W'(limit_q)) begin
					first_nxt = CNT_W'(fpage);
					last_nxt  = CNT_W'(fpage) + CNT_W'(1);
				end
			end
			CMD_RELEASE: begin
				first_nxt = (s_up > (RPG_W+1)'(PAGES)) ? CNT_W'(PAGES) : CNT_W'(s_up);
				last_nxt  = (end_q[RANGE_W-1:PAGE_SH] > RPG_W'(PAGES)) ? CNT_W'(PAGES)
				                                                      : CNT_W'(end_q[RANGE_W-1:PAGE_SH]);
				if (last_nxt > limit_q) begin
					limit_nxt = last_nxt;
				end
			end
			CMD_RESERVE: begin
				if (start_q[RANGE_W-1:PAGE_SH] < RPG_W'(PAGES)) begin
					first_nxt = CNT_W'(start_q[RANGE_W-1:PAGE_SH]);
					last_nxt  = (e_up > (RPG_W+1)'(PAGES)) ? CNT_W'(PAGES) : CNT_W'(e_up);
				end
			end
			default: begin
				first_nxt = '0;
			end
		endcase
	end

	// word mask of pages inside the range
	always_comb begin
		pg_i = '0;
		for (int i = 0; i < WORD_W; i++) begin
			pg_i    = {w_q, BIT_W'(i)};
			mask[i] = (pg_i >= IDX_W'(first_q)) && (pg_i < IDX_W'(last_q));
		end
	end

	// lowest free page of the word
	assign cand   = ~rdata_q & mask;
	assign onehot = cand & (~cand + WORD_W'(1));

	always_comb begin
		bit_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (onehot[i]) begin
				bit_idx = bit_idx | BIT_W'(i);
			end
		end
	end

	// new word and the bits that flip
	always_comb begin
		unique case (cmd_q)
			CMD_ALLOC: begin
				new_word = rdata_q | onehot;
				changed  = onehot;
			end
			CMD_RESERVE: begin
				new_word = rdata_q | mask;
				changed  = ~rdata_q & mask;
			end
			default: begin
				new_word = rdata_q & ~mask;
				changed  = rdata_q & mask;
			end
		endcase
	end

	// bitmap memory: clear pass, read, write back
	always_ff @(posedge clk) begin
		if (ctrl.clr_wr) begin
			map_mem[w_q[WADDR_W-1:0]] <= '1;
		end else if (ctrl.modify) begin
			map_mem[w_q[WADDR_W-1:0]] <= new_word;
		end
		if (ctrl.rd) begin
			rdata_q <= map_mem[w_q[WADDR_W-1:0]];
		end
	end

	// per-byte counts of flipped bits
	always_ff @(posedge clk) begin
		if (ctrl.modify) begin
			for (int b = 0; b < BYTE_CNT; b++) begin
				bcnt_q[b] <= 4'($countones(changed[b*8 +: 8]));
			end
			if (cmd_q == CMD_ALLOC) begin
				apage_q <= PG_W'({w_q, bit_idx});
			end
		end
	end

	always_comb begin
		delta = '0;
		for (int b = 0; b < BYTE_CNT; b++) begin
			delta = delta + DELTA_W'(bcnt_q[b]);
		end
	end

	// control and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= '0;
			first_q <= '0;
			last_q  <= '0;
			limit_q <= '0;
			free_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctrl.clr_wr) begin
				w_q <= w_q + WCNT_W'(1);
			end
			if (ctrl.load) begin
				found_q <= 1'b0;
			end
			if (ctrl.setup) begin
				first_q <= first_nxt;
				last_q  <= last_nxt;
				limit_q <= limit_nxt;
				w_q     <= WCNT_W'(first_nxt >> BIT_W);
			end
			if (ctrl.modify) begin
				w_q <= w_q + WCNT_W'(1);
				if (cmd_q == CMD_ALLOC && cand != '0) begin
					found_q <= 1'b1;
				end
			end
			if (ctrl.acc) begin
				if (cmd_q == CMD_ALLOC || cmd_q == CMD_RESERVE) begin
					free_q <= free_q - CNT_W'(delta);
				end else begin
					free_q <= free_q + CNT_W'(delta);
				end
			end
		end
	end

	// status and results
	assign stat.more     = (first_q < last_q) && ({w_q, BIT_W'(0)} < IDX_W'(last_q));
	assign stat.found    = found_q;
	assign stat.clr_last = (w_q == WCNT_W'(MAP_WORDS - 1));

	assign alloc_addr = (cmd_q == CMD_ALLOC && found_q) ? AADDR_W'({apage_q, PAGE_SH'(0)}) : '0;
	assign limit      = TOTAL_W'(limit_q);
	assign free_cnt   = TOTAL_W'(free_q);

endmodule

`default_nettype wire

/* design/bitmap_page_allocator_top.sv */
// Bitmap page allocator: 64-bit word walk over a 1024-word map, one result register.
// Setup, then per word visited: read, write back, count; allocate stops at a found page.
// Allocate and range commands visit up to 1024 words; freeing a page visits at most one.
// The next command can be taken in the cycle after the result loads, even if that result waits.
// After reset a clear pass over all 1024 map words marks every page used; no command is taken until it ends.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
`default_nettype none

module bitmap_page_allocator_top
	import bpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [PADDR_W-1:0] page_address,
	input  wire logic [RANGE_W-1:0] range_start,
	input  wire logic [RANGE_W-1:0] range_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [AADDR_W-1:0]      alloc_address,
	output logic [TOTAL_W-1:0]      total_pages,
	output logic [TOTAL_W-1:0]      free_pages
);

	dp_ctrl_t            ctrl;
	dp_stat_t            stat;
	logic                out_load;
	logic                out_busy;
	logic                out_valid_q;
	logic [AADDR_W-1:0]  res_addr;
	logic [TOTAL_W-1:0]  res_total;
	logic [TOTAL_W-1:0]  res_free;
	logic [AADDR_W-1:0]  addr_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  free_q;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_stall (in_stall),
		.out_load (out_load)
	);

	bpa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cmd          (cmd),
		.page_address (page_address),
		.range_start  (range_start),
		.range_end    (range_end),
		.stat         (stat),
		.alloc_addr   (res_addr),
		.limit        (res_total),
		.free_cnt     (res_free)
	);

	// result beat waits here until taken
	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			addr_q  <= res_addr;
			total_q <= res_total;
			free_q  <= res_free;
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = addr_q;
	assign total_pages   = total_q;
	assign free_pages    = free_q;

endmodule

`default_nettype wire

/* tb/tb_bitmap_page_allocator_top.sv */
// Self-checking testbench for bitmap_page_allocator_top: a directed table, then random commands.
// Results are checked against table values or a page map model; depends on bpa_pkg and the DUT.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_top
	import bpa_pkg::*;
();

	localparam longint unsigned PAGE_COUNT  = PAGES;
	localparam int              RANDOM_CMDS = 925;
	localparam int              PHASE_LEN   = 60;
	// a full map walk over all 1024 words, with margin
	localparam int              DRAIN_CYCLES = 3200;

	typedef struct packed {
		logic [AADDR_W-1:0] alloc_addr;
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] free_cnt;
	} page_report_t;

	typedef struct packed {
		cmd_t               op;
		logic [PADDR_W-1:0] paddr;
		logic [RANGE_W-1:0] rs;
		logic [RANGE_W-1:0] re;
		logic               has_want;
		page_report_t       want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd;
	logic [PADDR_W-1:0] page_address;
	logic [RANGE_W-1:0] range_start;
	logic [RANGE_W-1:0] range_end;
	logic               out_valid;
	logic               out_stall;
	logic [AADDR_W-1:0] alloc_address;
	logic [TOTAL_W-1:0] total_pages;
	logic [TOTAL_W-1:0] free_pages;

	// model of the allocator state
	bit              page_taken [PAGES];
	longint unsigned map_limit;
	longint unsigned model_free;

	page_report_t pending_reports[$];
	stim_row_t    directed_rows[$];

	int sender_idle_pct;
	int recv_stall_pct;
	int errors = 0;
	int results_seen = 0;
	int pages_granted = 0;

	bitmap_page_allocator_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.page_address  (page_address),
		.range_start   (range_start),
		.range_end     (range_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.alloc_address (alloc_address),
		.total_pages   (total_pages),
		.free_pages    (free_pages)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop for a hung design
	initial begin
		#250_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// apply one command to the model map and return the report it produces
	function automatic page_report_t run_page_command(input cmd_t op,
			input logic [PADDR_W-1:0] paddr, input logic [RANGE_W-1:0] rs,
			input logic [RANGE_W-1:0] re);
		page_report_t    rep;
		longint unsigned first;
		longint unsigned last;
		longint unsigned pg;
		longint unsigned byte_addr;
		rep = '0;
		case (op)
			CMD_ALLOC: begin
				// first fit from page 1; page 0 is never handed out
				for (pg = 1; pg < map_limit && pg < PAGE_COUNT; pg++) begin
					if (!page_taken[pg]) begin
						page_taken[pg] = 1'b1;
						model_free--;
						byte_addr = pg << PAGE_SH;
						rep.alloc_addr = byte_addr[AADDR_W-1:0];
						break;
					end
				end
			end
			CMD_FREE: begin
				pg = {32'd0, paddr} >> PAGE_SH;
				if (pg != 0 && pg < map_limit && pg < PAGE_COUNT && page_taken[pg]) begin
					page_taken[pg] = 1'b0;
					model_free++;
				end
			end
			CMD_RELEASE: begin
				// round start up, end down, clamp to the map
				first = (rs >> PAGE_SH) + ((rs[PAGE_SH-1:0] != 0) ? 64'd1 : 64'd0);
				last = re >> PAGE_SH;
				if (last > PAGE_COUNT)
					last = PAGE_COUNT;
				for (pg = first; pg < last; pg++) begin
					if (page_taken[pg]) begin
						page_taken[pg] = 1'b0;
						model_free++;
					end
				end
				if (last > map_limit)
					map_limit = last;
			end
			default: begin
				// round outward; a start beyond the map does nothing
				first = rs >> PAGE_SH;
				last = (re >> PAGE_SH) + ((re[PAGE_SH-1:0] != 0) ? 64'd1 : 64'd0);
				if (first < PAGE_COUNT) begin
					if (last > PAGE_COUNT)
						last = PAGE_COUNT;
					for (pg = first; pg < last; pg++) begin
						if (!page_taken[pg]) begin
							page_taken[pg] = 1'b1;
							model_free--;
						end
					end
				end
			end
		endcase
		rep.total = map_limit[TOTAL_W-1:0];
		rep.free_cnt = model_free[TOTAL_W-1:0];
		return rep;
	endfunction

	function automatic void add_row(input cmd_t op, input logic [PADDR_W-1:0] pa,
			input logic [RANGE_W-1:0] rs, input logic [RANGE_W-1:0] re,
			input logic has_want, input logic [AADDR_W-1:0] a,
			input logic [TOTAL_W-1:0] t, input logic [TOTAL_W-1:0] f);
		stim_row_t row;
		row.op = op;
		row.paddr = pa;
		row.rs = rs;
		row.re = re;
		row.has_want = has_want;
		row.want.alloc_addr = a;
		row.want.total = t;
		row.want.free_cnt = f;
		directed_rows.push_back(row);
	endfunction

	// mostly small ranges and low pages so the map walks stay short
	function automatic stim_row_t random_command();
		stim_row_t   row;
		int unsigned sel;
		int unsigned base_pg;
		int unsigned span;
		row = '0;
		sel = $urandom_range(99);
		if (sel < 35)
			row.op = CMD_ALLOC;
		else if (sel < 60)
			row.op = CMD_FREE;
		else if (sel < 80)
			row.op = CMD_RELEASE;
		else
			row.op = CMD_RESERVE;
		if ($urandom_range(9) < 7)
			row.paddr = ($urandom_range(1023) << PAGE_SH) | ($urandom & 32'hfff);
		else
			row.paddr = $urandom;
		sel = $urandom_range(99);
		if (sel < 80) begin
			base_pg = $urandom_range(1023);
			span = $urandom_range(64);
			row.rs = {32'd0, base_pg} << PAGE_SH;
			if ($urandom_range(1) != 0)
				row.rs = row.rs | {32'd0, $urandom_range(4095)};
			row.re = {32'd0, base_pg + span} << PAGE_SH;
			if ($urandom_range(1) != 0)
				row.re = row.re | {32'd0, $urandom_range(4095)};
		end else if (sel < 95) begin
			row.rs = {$urandom, $urandom};
			row.re = {$urandom, $urandom};
		end else begin
			// low start, far end: sweeps the whole map
			row.rs = {32'd0, $urandom_range(1023) << PAGE_SH};
			row.re = {$urandom, $urandom};
		end
		return row;
	endfunction

	// present one beat, hold it through stall, then log the expected report
	task automatic send_command(input stim_row_t row);
		page_report_t want;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= row.op;
		page_address <= row.paddr;
		range_start <= row.rs;
		range_end <= row.re;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = run_page_command(row.op, row.paddr, row.rs, row.re);
		if (row.has_want)
			want = row.want;
		pending_reports.push_back(want);
	endtask

	// randomize receiver backpressure
	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		page_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (alloc_address != 0)
				pages_granted++;
			if (pending_reports.size() == 0) begin
				$error("unexpected result beat: alloc_address %0h total_pages %0d free_pages %0d",
					alloc_address, total_pages, free_pages);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (alloc_address !== want.alloc_addr) begin
					$error("alloc_address: expected %0h, got %0h", want.alloc_addr, alloc_address);
					errors++;
				end
				if (total_pages !== want.total) begin
					$error("total_pages: expected %0d, got %0d", want.total, total_pages);
					errors++;
				end
				if (free_pages !== want.free_cnt) begin
					$error("free_pages: expected %0d, got %0d", want.free_cnt, free_pages);
					errors++;
				end
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		page_address = '0;
		range_start = '0;
		range_end = '0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (page_taken[k])
			page_taken[k] = 1'b1;
		map_limit = 0;
		model_free = 0;

		// empty map: nothing known, nothing free
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h0, 17'd0, 17'd0);
		add_row(CMD_FREE,    32'h5000, 64'h0, 64'h0, 1'b1, 28'h0, 17'd0, 17'd0);
		// start rounds up to page 2, end down to page 5
		add_row(CMD_RELEASE, 32'h0, 64'h1001, 64'h5000, 1'b1, 28'h0, 17'd5, 17'd3);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h2000, 17'd5, 17'd2);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h3000, 17'd5, 17'd1);
		add_row(CMD_FREE,    32'h2fff, 64'h0, 64'h0, 1'b1, 28'h0, 17'd5, 17'd2);
		// already free, page zero, and past the limit are all ignored
		add_row(CMD_FREE,    32'h2000, 64'h0, 64'h0, 1'b1, 28'h0, 17'd5, 17'd2);
		add_row(CMD_FREE,    32'h0, 64'h0, 64'h0, 1'b1, 28'h0, 17'd5, 17'd2);
		add_row(CMD_FREE,    32'h5000, 64'h0, 64'h0, 1'b1, 28'h0, 17'd5, 17'd2);
		// reserve rounds outward over a used and a free page
		add_row(CMD_RESERVE, 32'h0, 64'h2fff, 64'h3001, 1'b0, 28'h0, 17'd0, 17'd0);
		// empty and inverted ranges
		add_row(CMD_RELEASE, 32'h0, 64'h0, 64'h0, 1'b1, 28'h0, 17'd5, 17'd1);
		add_row(CMD_RELEASE, 32'h0, 64'h3000, 64'h2000, 1'b1, 28'h0, 17'd5, 17'd1);
		// an empty range still raises the limit
		add_row(CMD_RELEASE, 32'h0, 64'h10000, 64'h10000, 1'b1, 28'h0, 17'd16, 17'd1);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h4000, 17'd16, 17'd0);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h0, 17'd16, 17'd0);
		// whole map freed, page zero included, end clamped
		add_row(CMD_RELEASE, 32'h0, 64'h0, '1, 1'b1, 28'h0, 17'd65536, 17'd65536);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b0, 28'h0, 17'd0, 17'd0);
		add_row(CMD_FREE,    32'hffff_ffff, 64'h0, 64'h0, 1'b1, 28'h0, 17'd65536, 17'd65535);
		// top page reserved then freed again
		add_row(CMD_RESERVE, 32'h0, 64'h0fff_ffff, 64'h1000_0000, 1'b0, 28'h0, 17'd0, 17'd0);
		add_row(CMD_FREE,    32'h0fff_f123, 64'h0, 64'h0, 1'b0, 28'h0, 17'd0, 17'd0);
		// reserve starting beyond the map does nothing
		add_row(CMD_RESERVE, 32'h0, 64'h1000_0000, '1, 1'b1, 28'h0, 17'd65536, 17'd65535);
		add_row(CMD_RESERVE, 32'h0, '1, '1, 1'b1, 28'h0, 17'd65536, 17'd65535);
		add_row(CMD_RELEASE, 32'h0, '1, '1, 1'b1, 28'h0, 17'd65536, 17'd65535);
		// end rounds up without wrap: whole map used, full walk on allocate
		add_row(CMD_RESERVE, 32'h0, 64'h0, 64'hffff_ffff_ffff_f001, 1'b1,
			28'h0, 17'd65536, 17'd0);
		add_row(CMD_ALLOC,   32'h0, 64'h0, 64'h0, 1'b1, 28'h0, 17'd65536, 17'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling
		foreach (directed_rows[r])
			send_command(directed_rows[r]);

		// random commands, rotating through idle and stall mixes
		for (i = 0; i < RANDOM_CMDS; i++) begin
			case ((i / PHASE_LEN) % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 88;
				end
				default: begin
					sender_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			send_command(random_command());
		end
		in_valid <= 1'b0;

		// drain, then watch for stray beats over one full map walk
		recv_stall_pct = 0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d directed and %0d random commands under four idle/stall mixes;",
			directed_rows.size(), RANDOM_CMDS);
		$display("checked %0d result beats, %0d of them granting a page.",
			results_seen, pages_granted);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
